>>> rtl/core/polygon_centroid_transform_defines.svh
// ----------------------------------------------------------------------------
// polygon_centroid_transform_defines.svh
// Assertion macros used by the checker file of the polygon block, pct_chk.
// ----------------------------------------------------------------------------
`ifndef POLYGON_CENTROID_TRANSFORM_DEFINES_SVH
`define POLYGON_CENTROID_TRANSFORM_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PCT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PCT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg
// Types, constants and arithmetic helpers of the polygon centroid transform.
// ----------------------------------------------------------------------------
package pct_pkg;

	localparam int NV  = 4;
	localparam int CAP = 32;
	localparam int IW  = $clog2(NV);
	localparam int CW  = $clog2(CAP + 1);

	typedef logic signed [31:0] q16_t;
	typedef logic signed [32:0] s33_t;
	typedef logic signed [65:0] prod_t;
	typedef logic signed [66:0] sum_t;
	typedef logic signed [52:0] nv_t;
	typedef logic signed [53:0] wide_t;

	localparam s33_t COS2      = 33'sd65496;
	localparam s33_t SIN2      = 33'sd2287;
	localparam q16_t ONE_Q16   = 32'sd65536;
	localparam logic [32:0] SCALE_MIN = 33'd655;
	localparam logic [32:0] SHEAR_MIN = 33'd6553;
	localparam logic [32:0] PICK_MAX  = 33'd196608;
	localparam sum_t PICK_R2   = 67'sd38654705664;

	localparam logic [2:0] CMD_PRESS   = 3'd0;
	localparam logic [2:0] CMD_RELEASE = 3'd1;
	localparam logic [2:0] CMD_DRAG    = 3'd2;
	localparam logic [2:0] CMD_CLEAR   = 3'd3;
	localparam logic [2:0] CMD_CLOSE   = 3'd4;

	localparam logic BTN_LEFT = 1'b0;

	localparam logic [2:0] MODE_NONE      = 3'd0;
	localparam logic [2:0] MODE_TRANSLATE = 3'd1;
	localparam logic [2:0] MODE_ROTATE    = 3'd2;
	localparam logic [2:0] MODE_SCALE     = 3'd3;
	localparam logic [2:0] MODE_SHEAR     = 3'd4;
	localparam logic [2:0] MODE_MIRROR_Y  = 3'd5;
	localparam logic [2:0] MODE_MIRROR_X  = 3'd6;
	localparam logic [2:0] MODE_SWAP      = 3'd7;

	localparam logic [1:0] CFG_MODE        = 2'd0;
	localparam logic [1:0] CFG_HALF_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HALF_HEIGHT = 2'd2;

	typedef enum logic [4:0] {
		DP_NOP, DP_LOAD, DP_DROP, DP_REL_L, DP_REL_R, DP_CLEAR, DP_CLOSE,
		DP_SQ_X, DP_SQ_Y, DP_PICK, DP_DELTA, DP_TRANSLATE, DP_CENTROID,
		DP_RELATIVE, DP_RS1, DP_RS2, DP_RSCMP, DP_FINIT, DP_DIV_X, DP_DIV_Y,
		DP_SET_X, DP_SET_Y, DP_MUL_XA, DP_MUL_XB, DP_MUL_YA, DP_MUL_YB,
		DP_ROUND, DP_WRITE, DP_MIRROR, DP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [IW-1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic sel_valid;
		logic div_x_go;
		logic div_y_go;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	function automatic logic [32:0] mag33(input s33_t v);
		mag33 = v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic q16_t sat32(input wide_t v);
		if (v > 54'sd2147483647)
			sat32 = 32'sh7fffffff;
		else if (v < -54'sd2147483648)
			sat32 = 32'sh80000000;
		else
			sat32 = v[31:0];
	endfunction

	function automatic nv_t rnd16(input sum_t v);
		logic [66:0] m;
		logic [66:0] r;
		nv_t q;
		m = v[66] ? 67'(-v) : 67'(v);
		r = (m + 67'd32768) >> 16;
		q = $signed({2'b00, r[50:0]});
		rnd16 = v[66] ? -q : q;
	endfunction

endpackage

>>> rtl/core/polygon_centroid_transform.sv
// ----------------------------------------------------------------------------
// polygon_centroid_transform
// Four-vertex polygon editor with drag transforms about the centroid.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  config   | cfg_we              | cfg_index, cfg_data
//  event in | in_valid / in_ready | command, button, pointer_x, pointer_y
//  report   | out_valid/out_ready | vertex_index, vertex_x, vertex_y, last,
//           |                     | selected_valid, selected_index, point_count,
//           |                     | closed
//
//  One event at a time; every event ends in four report beats.
//  Rotate, scale and shear drags use the shared multiplier; scale and shear
//  may also use the bit-serial divider: scale may run both 49-step divides,
//  shear needs at most one divide.
//  in_ready is low from acceptance until the last report beat is loaded.
//  Reset: asynchronous, clears vertices, counters and selection; config to defaults.
// ----------------------------------------------------------------------------
module polygon_centroid_transform import pct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [11:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] command,
	input  logic button,
	input  logic [11:0] pointer_x,
	input  logic [11:0] pointer_y,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] vertex_index,
	output logic signed [31:0] vertex_x,
	output logic signed [31:0] vertex_y,
	output logic last,
	output logic selected_valid,
	output logic [1:0] selected_index,
	output logic [5:0] point_count,
	output logic closed
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.button   (button),
		.stat     (stat),
		.cmd      (cmd)
	);

	pct_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pointer_x      (pointer_x),
		.pointer_y      (pointer_y),
		.cmd            (cmd),
		.stat           (stat),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.vertex_index   (vertex_index),
		.vertex_x       (vertex_x),
		.vertex_y       (vertex_y),
		.last           (last),
		.selected_valid (selected_valid),
		.selected_index (selected_index),
		.point_count    (point_count),
		.closed         (closed)
	);

endmodule

>>> rtl/core/pct_div.sv
// ----------------------------------------------------------------------------
// pct_div
// Restoring divider for Q16.16 ratios, one quotient bit per cycle, saturated.
// ----------------------------------------------------------------------------
module pct_div import pct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  s33_t num,
	input  s33_t den,
	output logic done,
	output q16_t quo
);

	localparam int DVW = 49;

	logic busy_q;
	logic done_q;
	logic [5:0] cnt_q;
	logic neg_q;
	logic [32:0] den_q;
	logic [32:0] rem_q;
	logic [DVW-1:0] dvd_q;

	logic [33:0] rem_sh;
	logic ge;
	logic [33:0] rem_sub;

	assign rem_sh  = {rem_q, dvd_q[DVW-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'(DVW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[32] ^ den[32];
			den_q <= mag33(den);
			dvd_q <= {mag33(num), 16'b0};
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[32:0] : rem_sh[32:0];
			dvd_q <= {dvd_q[DVW-2:0], ge};
		end
	end

	always_comb begin
		if (neg_q) begin
			if (dvd_q > DVW'(64'h80000000))
				quo = 32'sh80000000;
			else
				quo = -$signed(dvd_q[31:0]);
		end else begin
			if (dvd_q > DVW'(64'h7fffffff))
				quo = 32'sh7fffffff;
			else
				quo = $signed(dvd_q[31:0]);
		end
	end

	assign done = done_q;

endmodule

>>> rtl/core/pct_dp.sv
// ----------------------------------------------------------------------------
// pct_dp
// Datapath: vertex store, shared multiplier and divider, output register.
// ----------------------------------------------------------------------------
module pct_dp import pct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [11:0] cfg_data,
	input  logic [11:0] pointer_x,
	input  logic [11:0] pointer_y,
	input  dp_cmd_t cmd,
	output dp_stat_t stat,
	input  logic out_ready,
	output logic out_valid,
	output logic [1:0] vertex_index,
	output q16_t vertex_x,
	output q16_t vertex_y,
	output logic last,
	output logic selected_valid,
	output logic [1:0] selected_index,
	output logic [5:0] point_count,
	output logic closed
);

	logic [2:0] mode_q;
	logic [11:0] hw_q;
	logic [11:0] hh_q;

	q16_t vx_q [NV];
	q16_t vy_q [NV];
	logic [CW-1:0] cnt_q;
	logic closed_q;
	logic sel_v_q;
	logic [IW-1:0] sel_i_q;

	q16_t px_q, py_q;
	s33_t dx_q, dy_q;
	q16_t cx_q, cy_q;
	s33_t rx_q [NV];
	s33_t ry_q [NV];
	q16_t fx_q, fy_q;
	logic neg_q;
	prod_t pxa_q, pxb_q, pya_q, pyb_q;
	nv_t nx_q, ny_q;
	logic out_valid_q;

	logic [IW-1:0] i;
	logic signed [12:0] cen_x, cen_y;
	s33_t ex, ey;
	q16_t vsx, vsy;
	s33_t rxs, rys;
	s33_t s_val;
	s33_t ma, mb;
	prod_t mp;
	logic dx_gt;
	s33_t dnum, dden;
	logic div_start, div_done;
	q16_t div_q;
	sum_t sum_x, sum_y;
	nv_t rnx, rny, nx_nx, ny_nx;
	logic signed [33:0] sum4x, sum4y;
	logic signed [33:0] avgx, avgy;
	logic pick_hit;

	assign i     = cmd.idx;
	assign cen_x = $signed({1'b0, pointer_x}) - $signed({1'b0, hw_q});
	assign cen_y = $signed({1'b0, hh_q}) - $signed({1'b0, pointer_y});
	assign ex    = 33'(vx_q[i]) - 33'(px_q);
	assign ey    = 33'(vy_q[i]) - 33'(py_q);
	assign vsx   = vx_q[sel_i_q];
	assign vsy   = vy_q[sel_i_q];
	assign rxs   = rx_q[sel_i_q];
	assign rys   = ry_q[sel_i_q];
	assign s_val = neg_q ? -SIN2 : SIN2;
	assign dx_gt = dx_q > dy_q;
	assign mp    = ma * mb;

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			DP_SQ_X: begin ma = ex; mb = ex; end
			DP_SQ_Y: begin ma = ey; mb = ey; end
			DP_RS1: begin ma = rys; mb = dx_q; end
			DP_RS2: begin ma = rxs; mb = dy_q; end
			DP_MUL_XA: begin
				if (mode_q == MODE_ROTATE) begin ma = rx_q[i]; mb = COS2; end
				else if (mode_q == MODE_SCALE) begin ma = rx_q[i]; mb = 33'(fx_q); end
				else begin ma = ry_q[i]; mb = 33'(fx_q); end
			end
			DP_MUL_XB: begin ma = ry_q[i]; mb = s_val; end
			DP_MUL_YA: begin
				if (mode_q == MODE_ROTATE) begin ma = rx_q[i]; mb = s_val; end
				else if (mode_q == MODE_SCALE) begin ma = ry_q[i]; mb = 33'(fy_q); end
				else begin ma = rx_q[i]; mb = 33'(fy_q); end
			end
			DP_MUL_YB: begin ma = ry_q[i]; mb = COS2; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	always_comb begin
		if (cmd.op == DP_DIV_Y) begin
			dnum = dy_q;
			dden = (mode_q == MODE_SCALE) ? rys : 33'(vsy);
		end else begin
			dnum = dx_q;
			dden = (mode_q == MODE_SCALE) ? rxs : 33'(vsx);
		end
	end

	assign div_start = (cmd.op == DP_DIV_X) || (cmd.op == DP_DIV_Y);

	pct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (dnum),
		.den    (dden),
		.done   (div_done),
		.quo    (div_q)
	);

	always_comb begin
		if (mode_q == MODE_ROTATE) begin
			sum_x = 67'(pxa_q) - 67'(pxb_q);
			sum_y = 67'(pya_q) + 67'(pyb_q);
		end else begin
			sum_x = 67'(pxa_q);
			sum_y = 67'(pya_q);
		end
		rnx = rnd16(sum_x);
		rny = rnd16(sum_y);
		if (mode_q == MODE_SHEAR) begin
			nx_nx = rnx + 53'(rx_q[i]);
			ny_nx = rny + 53'(ry_q[i]);
		end else begin
			nx_nx = rnx;
			ny_nx = rny;
		end
	end

	always_comb begin
		sum4x = '0;
		sum4y = '0;
		for (int k = 0; k < NV; k++) begin
			sum4x = sum4x + 34'(vx_q[k]);
			sum4y = sum4y + 34'(vy_q[k]);
		end
		avgx = sum4x[33] ? ((sum4x + 34'sd3) >>> 2) : (sum4x >>> 2);
		avgy = sum4y[33] ? ((sum4y + 34'sd3) >>> 2) : (sum4y >>> 2);
	end

	assign pick_hit = !sel_v_q && (mag33(ex) < PICK_MAX) && (mag33(ey) < PICK_MAX) &&
		((67'(pxa_q) + 67'(pya_q)) < PICK_R2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
			hw_q   <= 12'd300;
			hh_q   <= 12'd250;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:        mode_q <= cfg_data[2:0];
				CFG_HALF_WIDTH:  hw_q   <= cfg_data;
				CFG_HALF_HEIGHT: hh_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NV; k++) begin
				vx_q[k] <= '0;
				vy_q[k] <= '0;
			end
			cnt_q    <= '0;
			closed_q <= 1'b0;
			sel_v_q  <= 1'b0;
			sel_i_q  <= '0;
		end else begin
			case (cmd.op)
				DP_DROP: begin
					sel_v_q <= 1'b0;
					sel_i_q <= '0;
				end
				DP_REL_L: begin
					if (!closed_q && cnt_q < CW'(CAP)) begin
						if (cnt_q < CW'(NV)) begin
							vx_q[cnt_q[IW-1:0]] <= px_q;
							vy_q[cnt_q[IW-1:0]] <= py_q;
						end
						cnt_q <= cnt_q + CW'(1);
					end
				end
				DP_REL_R: begin
					if (cnt_q != '0)
						closed_q <= 1'b1;
				end
				DP_CLOSE: closed_q <= 1'b1;
				DP_CLEAR: begin
					for (int k = 0; k < NV; k++) begin
						vx_q[k] <= '0;
						vy_q[k] <= '0;
					end
					cnt_q    <= '0;
					closed_q <= 1'b0;
					sel_v_q  <= 1'b0;
					sel_i_q  <= '0;
				end
				DP_PICK: begin
					if (pick_hit) begin
						sel_v_q <= 1'b1;
						sel_i_q <= i;
					end
				end
				DP_TRANSLATE: begin
					for (int k = 0; k < NV; k++) begin
						vx_q[k] <= sat32(54'(vx_q[k]) + 54'(dx_q));
						vy_q[k] <= sat32(54'(vy_q[k]) + 54'(dy_q));
					end
				end
				DP_WRITE: begin
					vx_q[i] <= sat32(54'(nx_q) + 54'(cx_q));
					vy_q[i] <= sat32(54'(ny_q) + 54'(cy_q));
				end
				DP_MIRROR: begin
					for (int k = 0; k < NV; k++) begin
						case (mode_q)
							MODE_MIRROR_Y: begin
								vx_q[k] <= sat32(54'(rx_q[k]) + 54'(cx_q));
								vy_q[k] <= sat32(-54'(ry_q[k]) + 54'(cy_q));
							end
							MODE_MIRROR_X: begin
								vx_q[k] <= sat32(-54'(rx_q[k]) + 54'(cx_q));
								vy_q[k] <= sat32(54'(ry_q[k]) + 54'(cy_q));
							end
							default: begin
								vx_q[k] <= sat32(54'(ry_q[k]) + 54'(cx_q));
								vy_q[k] <= sat32(54'(rx_q[k]) + 54'(cy_q));
							end
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				px_q <= {{3{cen_x[12]}}, cen_x, 16'b0};
				py_q <= {{3{cen_y[12]}}, cen_y, 16'b0};
			end
			DP_SQ_X, DP_RS1, DP_MUL_XA: pxa_q <= mp;
			DP_SQ_Y, DP_MUL_YA: pya_q <= mp;
			DP_RS2, DP_MUL_XB: pxb_q <= mp;
			DP_MUL_YB: pyb_q <= mp;
			DP_DELTA: begin
				dx_q <= 33'(px_q) - 33'(vsx);
				dy_q <= 33'(py_q) - 33'(vsy);
			end
			DP_CENTROID: begin
				cx_q <= avgx[31:0];
				cy_q <= avgy[31:0];
			end
			DP_RELATIVE: begin
				for (int k = 0; k < NV; k++) begin
					rx_q[k] <= 33'(vx_q[k]) - 33'(cx_q);
					ry_q[k] <= 33'(vy_q[k]) - 33'(cy_q);
				end
			end
			DP_RSCMP: neg_q <= pxa_q > pxb_q;
			DP_FINIT: begin
				fx_q <= (mode_q == MODE_SHEAR) ? '0 : ONE_Q16;
				fy_q <= (mode_q == MODE_SHEAR) ? '0 : ONE_Q16;
			end
			DP_SET_X: fx_q <= (mode_q == MODE_SCALE) ?
				sat32(54'(div_q) + 54'(ONE_Q16)) : div_q;
			DP_SET_Y: fy_q <= (mode_q == MODE_SCALE) ?
				sat32(54'(div_q) + 54'(ONE_Q16)) : div_q;
			DP_ROUND: begin
				nx_q <= nx_nx;
				ny_q <= ny_nx;
			end
			DP_EMIT: begin
				vertex_index   <= 2'(i);
				vertex_x       <= vx_q[i];
				vertex_y       <= vy_q[i];
				last           <= i == IW'(NV - 1);
				selected_valid <= sel_v_q;
				selected_index <= 2'(sel_i_q);
				point_count    <= 6'(cnt_q);
				closed         <= closed_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == DP_EMIT)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat.mode      = mode_q;
		stat.sel_valid = sel_v_q;
		stat.div_done  = div_done;
		stat.out_free  = !out_valid_q || out_ready;
		stat.div_x_go  = 1'b0;
		stat.div_y_go  = 1'b0;
		if (mode_q == MODE_SCALE) begin
			stat.div_x_go = mag33(rxs) > SCALE_MIN;
			stat.div_y_go = mag33(rys) > SCALE_MIN;
		end else if (mode_q == MODE_SHEAR) begin
			stat.div_x_go = dx_gt && (mag33(33'(vsx)) > SHEAR_MIN);
			stat.div_y_go = !dx_gt && (mag33(33'(vsy)) > SHEAR_MIN);
		end
	end

endmodule

>>> rtl/core/pct_ctrl.sv
// ----------------------------------------------------------------------------
// pct_ctrl
// Sequencer: decodes each pointer event into datapath steps and the report.
// ----------------------------------------------------------------------------
module pct_ctrl import pct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] command,
	input  logic button,
	input  dp_stat_t stat,
	output dp_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_SQ_X, S_SQ_Y, S_PICK, S_REL_L, S_REL_R, S_CLEAR,
		S_CLOSE, S_DELTA, S_TRANSLATE, S_CENTROID, S_RELATIVE, S_RS1, S_RS2,
		S_RSCMP, S_FINIT, S_DIV_X, S_WAIT_X, S_SET_X, S_DIV_Y, S_WAIT_Y,
		S_SET_Y, S_XA, S_XB, S_YA, S_YB, S_ROUND, S_WRITE, S_MIRROR, S_REPORT
	} state_t;

	state_t state_q;
	logic [IW-1:0] idx_q;
	logic [2:0] cmd_q;
	logic btn_q;
	logic idx_last;

	assign idx_last = idx_q == IW'(NV - 1);
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd.idx = idx_q;
		cmd.op  = DP_NOP;
		unique case (state_q)
			S_IDLE:      cmd.op = in_valid ? DP_LOAD : DP_NOP;
			S_DECODE:    cmd.op = (cmd_q == CMD_PRESS || cmd_q == CMD_RELEASE) ?
				DP_DROP : DP_NOP;
			S_SQ_X:      cmd.op = DP_SQ_X;
			S_SQ_Y:      cmd.op = DP_SQ_Y;
			S_PICK:      cmd.op = DP_PICK;
			S_REL_L:     cmd.op = DP_REL_L;
			S_REL_R:     cmd.op = DP_REL_R;
			S_CLEAR:     cmd.op = DP_CLEAR;
			S_CLOSE:     cmd.op = DP_CLOSE;
			S_DELTA:     cmd.op = DP_DELTA;
			S_TRANSLATE: cmd.op = DP_TRANSLATE;
			S_CENTROID:  cmd.op = DP_CENTROID;
			S_RELATIVE:  cmd.op = DP_RELATIVE;
			S_RS1:       cmd.op = DP_RS1;
			S_RS2:       cmd.op = DP_RS2;
			S_RSCMP:     cmd.op = DP_RSCMP;
			S_FINIT:     cmd.op = DP_FINIT;
			S_DIV_X:     cmd.op = DP_DIV_X;
			S_WAIT_X:    cmd.op = DP_NOP;
			S_SET_X:     cmd.op = DP_SET_X;
			S_DIV_Y:     cmd.op = DP_DIV_Y;
			S_WAIT_Y:    cmd.op = DP_NOP;
			S_SET_Y:     cmd.op = DP_SET_Y;
			S_XA:        cmd.op = DP_MUL_XA;
			S_XB:        cmd.op = DP_MUL_XB;
			S_YA:        cmd.op = DP_MUL_YA;
			S_YB:        cmd.op = DP_MUL_YB;
			S_ROUND:     cmd.op = DP_ROUND;
			S_WRITE:     cmd.op = DP_WRITE;
			S_MIRROR:    cmd.op = DP_MIRROR;
			S_REPORT:    cmd.op = stat.out_free ? DP_EMIT : DP_NOP;
			default:     cmd.op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			cmd_q   <= CMD_PRESS;
			btn_q   <= BTN_LEFT;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= command;
						btn_q   <= button;
						idx_q   <= '0;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					unique case (cmd_q)
						CMD_PRESS:   state_q <= (btn_q == BTN_LEFT) ? S_SQ_X : S_REPORT;
						CMD_RELEASE: state_q <= (btn_q == BTN_LEFT) ? S_REL_L : S_REL_R;
						CMD_DRAG:    state_q <= (stat.sel_valid && stat.mode != MODE_NONE) ?
							S_DELTA : S_REPORT;
						CMD_CLEAR:   state_q <= S_CLEAR;
						CMD_CLOSE:   state_q <= S_CLOSE;
						default:     state_q <= S_REPORT;
					endcase
				end
				S_SQ_X: state_q <= S_SQ_Y;
				S_SQ_Y: state_q <= S_PICK;
				S_PICK: begin
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= S_REPORT;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_SQ_X;
					end
				end
				S_REL_L, S_REL_R, S_CLEAR, S_CLOSE, S_TRANSLATE, S_MIRROR:
					state_q <= S_REPORT;
				S_DELTA: state_q <= (stat.mode == MODE_TRANSLATE) ? S_TRANSLATE : S_CENTROID;
				S_CENTROID: state_q <= S_RELATIVE;
				S_RELATIVE: begin
					if (stat.mode == MODE_ROTATE)
						state_q <= S_RS1;
					else if (stat.mode == MODE_SCALE || stat.mode == MODE_SHEAR)
						state_q <= S_FINIT;
					else
						state_q <= S_MIRROR;
				end
				S_RS1: state_q <= S_RS2;
				S_RS2: state_q <= S_RSCMP;
				S_RSCMP: state_q <= S_XA;
				S_FINIT: begin
					if (stat.div_x_go)
						state_q <= S_DIV_X;
					else if (stat.div_y_go)
						state_q <= S_DIV_Y;
					else
						state_q <= S_XA;
				end
				S_DIV_X: state_q <= S_WAIT_X;
				S_WAIT_X: if (stat.div_done) state_q <= S_SET_X;
				S_SET_X: state_q <= stat.div_y_go ? S_DIV_Y : S_XA;
				S_DIV_Y: state_q <= S_WAIT_Y;
				S_WAIT_Y: if (stat.div_done) state_q <= S_SET_Y;
				S_SET_Y: state_q <= S_XA;
				S_XA: state_q <= (stat.mode == MODE_ROTATE) ? S_XB : S_YA;
				S_XB: state_q <= S_YA;
				S_YA: state_q <= (stat.mode == MODE_ROTATE) ? S_YB : S_ROUND;
				S_YB: state_q <= S_ROUND;
				S_ROUND: state_q <= S_WRITE;
				S_WRITE: begin
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= S_REPORT;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_XA;
					end
				end
				S_REPORT: begin
					if (stat.out_free) begin
						if (idx_last) begin
							idx_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/pct_chk.sv
// ----------------------------------------------------------------------------
// pct_chk
// Port-level checker for the polygon centroid transform, bound to the top.
// ----------------------------------------------------------------------------
`include "polygon_centroid_transform_defines.svh"

module pct_chk import pct_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] vertex_index,
	input logic signed [31:0] vertex_x,
	input logic signed [31:0] vertex_y,
	input logic last,
	input logic selected_valid,
	input logic [1:0] selected_index,
	input logic [5:0] point_count
);

	`PCT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(vertex_x) && $stable(vertex_y) && $stable(vertex_index), "report beat changed while stalled")
	`PCT_HOLDS(a_last_idx, out_valid, last == (vertex_index == IW'(NV - 1)), "last flag off the final vertex")
	`PCT_HOLDS(a_count_cap, out_valid, point_count <= CW'(CAP), "point count beyond capacity")
	`PCT_HOLDS(a_sel_idx, out_valid && !selected_valid, selected_index == '0, "selection index without selection")
	`PCT_NEXT(a_busy, in_valid && in_ready, !in_ready, "event taken while busy")

endmodule

bind polygon_centroid_transform pct_chk u_pct_chk (.*);
